[design/aavr_pkg.sv]
`default_nettype none

package aavr_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned CordicStagesDef  = 16;
  localparam int unsigned ComponentBitsDef = 16;

  // Fixed formats of the datapath.
  localparam int unsigned AngleBits = 16;
  localparam int unsigned NormBits  = 32;  // width of a normalized axis magnitude
  localparam int unsigned SqrtSteps = 32;  // one result bit per stage
  localparam int unsigned DivSteps  = 32;  // one quotient bit per stage
  localparam int unsigned KBits     = 32;  // signed Q2.30 unit axis component
  localparam int unsigned CsBits    = 34;  // CORDIC x, y and z
  localparam int unsigned QFrac     = 30;
  localparam int unsigned RndBits   = 80;  // wide enough for every rounded product

  localparam logic signed [CsBits-1:0] CordicGain = 34'sd652032874;

  typedef enum logic [1:0] {
    Quad0,
    Quad1,
    Quad2,
    Quad3
  } quad_e;

  // atan(2^-i) where 2^32 is one full turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:    val = 32'h20000000;
      5'd1:    val = 32'h12E4051D;
      5'd2:    val = 32'h09FB385B;
      5'd3:    val = 32'h051111D4;
      5'd4:    val = 32'h028B0D43;
      5'd5:    val = 32'h0145D7E1;
      5'd6:    val = 32'h00A2F61E;
      5'd7:    val = 32'h00517C55;
      5'd8:    val = 32'h0028BE53;
      5'd9:    val = 32'h00145F2E;
      5'd10:   val = 32'h000A2F98;
      5'd11:   val = 32'h000517CC;
      5'd12:   val = 32'h00028BE6;
      5'd13:   val = 32'h000145F3;
      5'd14:   val = 32'h0000A2F9;
      5'd15:   val = 32'h0000517C;
      5'd16:   val = 32'h000028BE;
      5'd17:   val = 32'h0000145F;
      5'd18:   val = 32'h00000A2F;
      5'd19:   val = 32'h00000517;
      5'd20:   val = 32'h0000028B;
      5'd21:   val = 32'h00000145;
      5'd22:   val = 32'h000000A2;
      5'd23:   val = 32'h00000051;
      5'd24:   val = 32'h00000028;
      5'd25:   val = 32'h00000014;
      5'd26:   val = 32'h0000000A;
      5'd27:   val = 32'h00000005;
      5'd28:   val = 32'h00000002;
      5'd29:   val = 32'h00000001;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

  // Round a Q30 product back to integer: add one half, shift right arithmetically.
  function automatic logic signed [RndBits-1:0] rnd_q30(input logic signed [RndBits-1:0] x);
    logic signed [RndBits-1:0] half;
    half = RndBits'(1) << (QFrac - 1);
    return (x + half) >>> QFrac;
  endfunction

endpackage

`default_nettype wire

[design/aavr_in_if.sv]
`default_nettype none

interface aavr_in_if #(
  parameter int unsigned W = aavr_pkg::ComponentBitsDef
);
  logic                              valid;
  logic                              ready;
  logic signed [W-1:0]               vec_x;
  logic signed [W-1:0]               vec_y;
  logic signed [W-1:0]               vec_z;
  logic signed [W-1:0]               axis_x;
  logic signed [W-1:0]               axis_y;
  logic signed [W-1:0]               axis_z;
  logic [aavr_pkg::AngleBits-1:0]    angle;

  modport source (
    output valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle,
    input  ready
  );
  modport sink (
    input  valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle,
    output ready
  );
endinterface

`default_nettype wire

[design/aavr_out_if.sv]
`default_nettype none

interface aavr_out_if #(
  parameter int unsigned W = aavr_pkg::ComponentBitsDef
);
  logic              valid;
  logic              ready;
  logic signed [W:0] rot_x;
  logic signed [W:0] rot_y;
  logic signed [W:0] rot_z;
  logic              axis_was_zero;

  modport source (
    output valid, rot_x, rot_y, rot_z, axis_was_zero,
    input  ready
  );
  modport sink (
    input  valid, rot_x, rot_y, rot_z, axis_was_zero,
    output ready
  );
endinterface

`default_nettype wire

[design/aavr_delay.sv]
`default_nettype none

module aavr_delay #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] pipe_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        pipe_q[i] <= pipe_q[i-1];
      end
    end
  end

  assign q_o = pipe_q[N-1];

endmodule

`default_nettype wire

[design/aavr_isqrt.sv]
`default_nettype none

module aavr_isqrt (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [2*aavr_pkg::SqrtSteps-1:0]    rad_i,
  output logic [aavr_pkg::SqrtSteps-1:0]      root_o
);

  localparam int unsigned Steps = aavr_pkg::SqrtSteps;
  localparam int unsigned RW    = 2 * Steps;

  logic [RW-1:0] rem_q [Steps];
  logic [RW-1:0] acc_q [Steps];
  logic [RW-1:0] rem_d [Steps];
  logic [RW-1:0] acc_d [Steps];

  // Digit-by-digit square root, one result bit per stage.
  always_comb begin
    logic [RW-1:0] prev_rem;
    logic [RW-1:0] prev_acc;
    logic [RW-1:0] bit_val;
    logic [RW-1:0] trial;
    for (int i = 0; i < Steps; i++) begin
      if (i == 0) begin
        prev_rem = rad_i;
        prev_acc = '0;
      end else begin
        prev_rem = rem_q[i-1];
        prev_acc = acc_q[i-1];
      end
      bit_val = RW'(1) << (RW - 2 - 2 * i);
      trial   = prev_acc + bit_val;
      if (prev_rem >= trial) begin
        rem_d[i] = prev_rem - trial;
        acc_d[i] = (prev_acc >> 1) + bit_val;
      end else begin
        rem_d[i] = prev_rem;
        acc_d[i] = prev_acc >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      acc_q <= acc_d;
    end
  end

  assign root_o = acc_q[Steps-1][Steps-1:0];

endmodule

`default_nettype wire

[design/aavr_div.sv]
`default_nettype none

module aavr_div (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [aavr_pkg::NormBits-1:0]   mag_i,
  input  logic [aavr_pkg::NormBits-1:0]   root_i,
  output logic [aavr_pkg::NormBits-1:0]   quo_o
);

  localparam int unsigned NB    = aavr_pkg::NormBits;
  localparam int unsigned Steps = aavr_pkg::DivSteps;
  localparam int unsigned DW    = NB + 1;
  localparam int unsigned RW    = NB + 2;
  localparam int unsigned TW    = NB + 3;

  // Quotient of (mag * 2^31 + n) by 2n: mag / n rounded half up in Q2.30.
  logic [2*NB-1:0] num;

  logic [RW-1:0] rem_q [Steps+1];
  logic [NB-1:0] low_q [Steps+1];
  logic [DW-1:0] den_q [Steps+1];
  logic [NB-1:0] quo_q [Steps+1];
  logic [RW-1:0] rem_d [Steps];
  logic [NB-1:0] low_d [Steps];
  logic [NB-1:0] quo_d [Steps];

  assign num = (2*NB)'({mag_i, (NB-1)'(0)}) + (2*NB)'(root_i);

  // Restoring division, one quotient bit per stage.
  always_comb begin
    logic [TW-1:0] trial;
    logic          take;
    for (int i = 0; i < Steps; i++) begin
      trial = {rem_q[i], low_q[i][NB-1]};
      take  = (trial >= TW'(den_q[i]));
      if (take) begin
        rem_d[i] = RW'(trial - TW'(den_q[i]));
      end else begin
        rem_d[i] = RW'(trial);
      end
      low_d[i] = low_q[i] << 1;
      quo_d[i] = {quo_q[i][NB-2:0], take};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= RW'(num[2*NB-1:NB]);
      low_q[0] <= num[NB-1:0];
      den_q[0] <= {root_i, 1'b0};
      quo_q[0] <= '0;
      for (int i = 0; i < Steps; i++) begin
        rem_q[i+1] <= rem_d[i];
        low_q[i+1] <= low_d[i];
        den_q[i+1] <= den_q[i];
        quo_q[i+1] <= quo_d[i];
      end
    end
  end

  assign quo_o = quo_q[Steps];

endmodule

`default_nettype wire

[design/aavr_cordic.sv]
`default_nettype none

module aavr_cordic #(
  parameter int unsigned STAGES = aavr_pkg::CordicStagesDef
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic [aavr_pkg::AngleBits-1:0]        angle_i,
  output logic signed [aavr_pkg::CsBits-1:0]    cos_o,
  output logic signed [aavr_pkg::CsBits-1:0]    sin_o
);

  localparam int unsigned CW = aavr_pkg::CsBits;
  localparam int unsigned AB = aavr_pkg::AngleBits;

  logic [AB-1:0]        fold;
  logic [1:0]           quad_init;
  logic [AB-1:0]        resid;

  logic signed [CW-1:0] x_q [STAGES+1];
  logic signed [CW-1:0] y_q [STAGES+1];
  logic signed [CW-1:0] z_q [STAGES+1];
  aavr_pkg::quad_e      quad_q [STAGES+1];
  logic signed [CW-1:0] x_d [STAGES];
  logic signed [CW-1:0] y_d [STAGES];
  logic signed [CW-1:0] z_d [STAGES];
  logic signed [CW-1:0] cos_q;
  logic signed [CW-1:0] sin_q;

  // Fold to the nearest quadrant; the residual lies within one eighth turn.
  assign fold      = angle_i + AB'(16'h2000);
  assign quad_init = fold[AB-1:AB-2];
  assign resid     = angle_i - {quad_init, (AB-2)'(0)};

  // Each rotation moves x by the shifted y and y by the shifted x.
  always_comb begin
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] step;
    for (int i = 0; i < STAGES; i++) begin
      dx   = y_q[i] >>> i;
      dy   = x_q[i] >>> i;
      step = $signed(CW'(aavr_pkg::atan_turn(5'(i))));
      if (!z_q[i][CW-1]) begin
        x_d[i] = x_q[i] - dx;
        y_d[i] = y_q[i] + dy;
        z_d[i] = z_q[i] - step;
      end else begin
        x_d[i] = x_q[i] + dx;
        y_d[i] = y_q[i] - dy;
        z_d[i] = z_q[i] + step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= aavr_pkg::CordicGain;
      y_q[0]    <= '0;
      z_q[0]    <= CW'($signed({resid, 16'h0000}));
      quad_q[0] <= aavr_pkg::quad_e'(quad_init);
      for (int i = 0; i < STAGES; i++) begin
        x_q[i+1]    <= x_d[i];
        y_q[i+1]    <= y_d[i];
        z_q[i+1]    <= z_d[i];
        quad_q[i+1] <= quad_q[i];
      end
      case (quad_q[STAGES])
        aavr_pkg::Quad0: begin
          cos_q <= x_q[STAGES];
          sin_q <= y_q[STAGES];
        end
        aavr_pkg::Quad1: begin
          cos_q <= -y_q[STAGES];
          sin_q <= x_q[STAGES];
        end
        aavr_pkg::Quad2: begin
          cos_q <= -x_q[STAGES];
          sin_q <= -y_q[STAGES];
        end
        default: begin
          cos_q <= y_q[STAGES];
          sin_q <= -x_q[STAGES];
        end
      endcase
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

`default_nettype wire

[design/aavr_combine.sv]
`default_nettype none

module aavr_combine #(
  parameter int unsigned CB = aavr_pkg::ComponentBitsDef
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [aavr_pkg::KBits-1:0]   k_i [3],
  input  logic signed [CB-1:0]                v_i [3],
  input  logic signed [aavr_pkg::CsBits-1:0]  cos_i,
  input  logic signed [aavr_pkg::CsBits-1:0]  sin_i,
  output logic signed [CB:0]                  rot_o [3]
);

  localparam int unsigned KW  = aavr_pkg::KBits;
  localparam int unsigned CW  = aavr_pkg::CsBits;
  localparam int unsigned RB  = aavr_pkg::RndBits;
  localparam int unsigned PW  = KW + CB;        // k times v
  localparam int unsigned XW  = CB + 5;         // rounded cross and dot terms
  localparam int unsigned TPW = KW + XW;        // k times dot
  localparam int unsigned TW  = TPW - 29;       // rounded k times dot
  localparam int unsigned OW  = CW + 1;         // one minus cosine
  localparam int unsigned AW  = CB + CW;
  localparam int unsigned BW  = XW + CW;
  localparam int unsigned CPW = TW + OW;
  localparam int unsigned SW  = CB + 16;        // sum of the three rounded terms

  localparam logic signed [SW-1:0] SatHi = $signed((SW'(1) << CB) - SW'(1));
  localparam logic signed [SW-1:0] SatLo = -SatHi - SW'(1);

  logic [3*CB-1:0]        v_pack;
  logic [3*CB-1:0]        v_late;
  logic signed [OW-1:0]   one_minus_cos;

  logic signed [PW-1:0]   s1_prod_q [3][3];
  logic signed [KW-1:0]   s1_k_q [3];
  logic signed [XW-1:0]   s2_cr_q [3];
  logic signed [XW-1:0]   s2_dot_q;
  logic signed [KW-1:0]   s2_k_q [3];
  logic signed [TPW-1:0]  s3_pt_q [3];
  logic signed [XW-1:0]   s3_cr_q [3];
  logic signed [TW-1:0]   s4_t_q [3];
  logic signed [XW-1:0]   s4_cr_q [3];
  logic signed [AW-1:0]   s5_pa_q [3];
  logic signed [BW-1:0]   s5_pb_q [3];
  logic signed [CPW-1:0]  s5_pc_q [3];
  logic signed [SW-1:0]   s6_sum_q [3];
  logic signed [CB:0]     s7_rot_q [3];

  // The vector is needed again four stages later, next to cosine and sine.
  assign v_pack = {v_i[2], v_i[1], v_i[0]};

  aavr_delay #(
    .W(3 * CB),
    .N(4)
  ) u_v_delay (
    .clk_i(clk_i),
    .en_i (en_i),
    .d_i  (v_pack),
    .q_o  (v_late)
  );

  assign one_minus_cos = $signed(OW'(1) << aavr_pkg::QFrac) - OW'(cos_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Every k_i times v_j: six for the cross product, three for the dot product.
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s1_prod_q[i][j] <= k_i[i] * v_i[j];
        end
      end
      s1_k_q <= k_i;

      s2_cr_q[0] <= XW'(aavr_pkg::rnd_q30(RB'(s1_prod_q[1][2]) - RB'(s1_prod_q[2][1])));
      s2_cr_q[1] <= XW'(aavr_pkg::rnd_q30(RB'(s1_prod_q[2][0]) - RB'(s1_prod_q[0][2])));
      s2_cr_q[2] <= XW'(aavr_pkg::rnd_q30(RB'(s1_prod_q[0][1]) - RB'(s1_prod_q[1][0])));
      s2_dot_q   <= XW'(aavr_pkg::rnd_q30(RB'(s1_prod_q[0][0]) + RB'(s1_prod_q[1][1])
                                          + RB'(s1_prod_q[2][2])));
      s2_k_q     <= s1_k_q;

      for (int i = 0; i < 3; i++) begin
        s3_pt_q[i] <= s2_k_q[i] * s2_dot_q;
        s3_cr_q[i] <= s2_cr_q[i];

        s4_t_q[i]  <= TW'(aavr_pkg::rnd_q30(RB'(s3_pt_q[i])));
        s4_cr_q[i] <= s3_cr_q[i];

        s5_pa_q[i] <= $signed(v_late[i*CB +: CB]) * cos_i;
        s5_pb_q[i] <= s4_cr_q[i] * sin_i;
        s5_pc_q[i] <= s4_t_q[i] * one_minus_cos;

        s6_sum_q[i] <= SW'(aavr_pkg::rnd_q30(RB'(s5_pa_q[i]))
                           + aavr_pkg::rnd_q30(RB'(s5_pb_q[i]))
                           + aavr_pkg::rnd_q30(RB'(s5_pc_q[i])));

        if (s6_sum_q[i] > SatHi) begin
          s7_rot_q[i] <= (CB+1)'(SatHi);
        end else if (s6_sum_q[i] < SatLo) begin
          s7_rot_q[i] <= (CB+1)'(SatLo);
        end else begin
          s7_rot_q[i] <= (CB+1)'(s6_sum_q[i]);
        end
      end
    end
  end

  assign rot_o = s7_rot_q;

endmodule

`default_nettype wire

[design/axis_angle_vector_rotate.sv]
`default_nettype none

// Rotates one 3-vector per item about an arbitrary axis by a binary angle
// (65536 is one full turn), using Rodrigues' formula in fixed point. The axis
// may have any nonzero length: it is scaled up, its length is found by a
// 32-stage pipelined square root and each component is divided by it in a
// 33-stage pipelined divider lane of its own, one lane per component. Cosine
// and sine come from a pipelined CORDIC of CORDIC_STAGES stages that runs
// alongside. A zero axis gives v times cosine and raises axis_was_zero.
// Results are clamped to COMPONENT_BITS+1 signed bits. The block takes one
// item every cycle unless the output stalls. An item passes 79 register stages,
// the first of which captures it at the accepting edge; most of them belong to
// the square root and divider chains. When the result register holds an item
// that the sink does not take, the whole pipeline holds and no new item is
// taken; empty stages never block the input.
module axis_angle_vector_rotate #(
  parameter int unsigned CORDIC_STAGES  = aavr_pkg::CordicStagesDef,
  parameter int unsigned COMPONENT_BITS = aavr_pkg::ComponentBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  aavr_in_if.sink    in_i,
  aavr_out_if.source out_o
);

  localparam int unsigned CB = COMPONENT_BITS;
  localparam int unsigned NB = aavr_pkg::NormBits;
  localparam int unsigned KW = aavr_pkg::KBits;
  localparam int unsigned CW = aavr_pkg::CsBits;
  localparam int unsigned AB = aavr_pkg::AngleBits;

  // Stage numbers, counted in register levels after acceptance.
  localparam int unsigned StN2  = 6;
  localparam int unsigned StRt  = StN2 + aavr_pkg::SqrtSteps;
  localparam int unsigned StQuo = StRt + 1 + aavr_pkg::DivSteps;
  localparam int unsigned StK   = StQuo + 1;
  localparam int unsigned StCs  = StK + 4;
  localparam int unsigned StOut = StK + 7;
  localparam int unsigned StAng = StCs - CORDIC_STAGES - 2;

  // The pipeline moves whenever the result register is free or being emptied.
  logic              en;
  logic [StOut-1:0]  vld_q;

  logic signed [CB-1:0] vin [3];
  logic signed [CB-1:0] ain [3];
  logic [NB-1:0]        amag [3];

  logic signed [CB-1:0] v1_q [3];
  logic [NB-1:0]        am1_q [3];
  logic [2:0]           as1_q;
  logic [AB-1:0]        ang1_q;

  logic [NB-1:0]        maxm;
  logic [NB-1:0]        maxm2_q;
  logic [NB-1:0]        am2_q [3];
  logic [2:0]           as2_q;

  logic [4:0]           lz;
  logic [NB-1:0]        lz_x;
  logic [4:0]           sh3_q;
  logic [NB-1:0]        am3_q [3];
  logic [2:0]           as3_q;
  logic                 zero3_q;

  logic [NB-1:0]        am4_q [3];
  logic [2*NB-1:0]      sq5_q [3];
  logic [NB-1:0]        am5_q [3];
  logic [2*NB-1:0]      n2_q;
  logic [NB-1:0]        am6_q [3];

  logic [3*NB-1:0]      am_late;
  logic [NB-1:0]        root;
  logic [NB-1:0]        quo [3];
  logic [3:0]           zs_late;
  logic                 zero_q71;
  logic signed [KW-1:0] k_q [3];

  logic [3*CB-1:0]      v_late;
  logic signed [CB-1:0] v_k [3];
  logic [AB-1:0]        ang_late;
  logic signed [CW-1:0] cos_v;
  logic signed [CW-1:0] sin_v;
  logic signed [CB:0]   rot [3];
  logic                 zero_out;

  assign en         = !vld_q[StOut-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[StOut-2:0], in_i.valid};
    end
  end

  assign vin[0] = in_i.vec_x;
  assign vin[1] = in_i.vec_y;
  assign vin[2] = in_i.vec_z;
  assign ain[0] = in_i.axis_x;
  assign ain[1] = in_i.axis_y;
  assign ain[2] = in_i.axis_z;

  // Axis magnitudes; the sign travels on its own.
  always_comb begin
    logic signed [NB:0] ext;
    for (int j = 0; j < 3; j++) begin
      ext = (NB+1)'(ain[j]);
      if (ain[j][CB-1]) begin
        amag[j] = NB'(-ext);
      end else begin
        amag[j] = NB'(ext);
      end
    end
  end

  always_comb begin
    maxm = am1_q[0];
    if (am1_q[1] > maxm) begin
      maxm = am1_q[1];
    end
    if (am1_q[2] > maxm) begin
      maxm = am1_q[2];
    end
  end

  // Leading-zero count in five halving steps.
  always_comb begin
    lz_x = maxm2_q;
    lz   = '0;
    if (lz_x[31:16] == '0) begin
      lz[4] = 1'b1;
      lz_x  = lz_x << 16;
    end
    if (lz_x[31:24] == '0) begin
      lz[3] = 1'b1;
      lz_x  = lz_x << 8;
    end
    if (lz_x[31:28] == '0) begin
      lz[2] = 1'b1;
      lz_x  = lz_x << 4;
    end
    if (lz_x[31:30] == '0) begin
      lz[1] = 1'b1;
      lz_x  = lz_x << 2;
    end
    if (!lz_x[31]) begin
      lz[0] = 1'b1;
    end
  end

  // Front end: capture, find the largest magnitude, scale it up to at least
  // 2^30, square and sum.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        v1_q[j]  <= vin[j];
        am1_q[j] <= amag[j];
        as1_q[j] <= ain[j][CB-1];
        am2_q[j] <= am1_q[j];
        am3_q[j] <= am2_q[j];
        am4_q[j] <= am3_q[j] << sh3_q;
        sq5_q[j] <= am4_q[j] * am4_q[j];
        am5_q[j] <= am4_q[j];
        am6_q[j] <= am5_q[j];
      end
      ang1_q  <= in_i.angle;
      maxm2_q <= maxm;
      as2_q   <= as1_q;
      as3_q   <= as2_q;
      zero3_q <= (maxm2_q == '0);
      sh3_q   <= (lz == '0) ? '0 : lz - 5'd1;
      n2_q    <= sq5_q[0] + sq5_q[1] + sq5_q[2];
    end
  end

  aavr_isqrt u_isqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .rad_i (n2_q),
    .root_o(root)
  );

  aavr_delay #(
    .W(3 * NB),
    .N(StRt - StN2)
  ) u_mag_delay (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  ({am6_q[2], am6_q[1], am6_q[0]}),
    .q_o  (am_late)
  );

  for (genvar g = 0; g < 3; g++) begin : g_lane
    aavr_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .mag_i (am_late[g*NB +: NB]),
      .root_i(root),
      .quo_o (quo[g])
    );
  end

  aavr_delay #(
    .W(4),
    .N(StQuo - 3)
  ) u_zs_delay (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  ({as3_q, zero3_q}),
    .q_o  (zs_late)
  );

  assign zero_q71 = zs_late[0];

  // Signed unit axis; a zero axis stays zero.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        if (zero_q71) begin
          k_q[j] <= '0;
        end else if (zs_late[j+1]) begin
          k_q[j] <= -$signed(quo[j]);
        end else begin
          k_q[j] <= $signed(quo[j]);
        end
      end
    end
  end

  aavr_delay #(
    .W(1),
    .N(StOut - StQuo)
  ) u_zero_delay (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  (zero_q71),
    .q_o  (zero_out)
  );

  aavr_delay #(
    .W(3 * CB),
    .N(StK - 1)
  ) u_vec_delay (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  ({v1_q[2], v1_q[1], v1_q[0]}),
    .q_o  (v_late)
  );

  assign v_k[0] = $signed(v_late[CB-1:0]);
  assign v_k[1] = $signed(v_late[2*CB-1:CB]);
  assign v_k[2] = $signed(v_late[3*CB-1:2*CB]);

  // The angle is held back so that cosine and sine land where they are used.
  aavr_delay #(
    .W(AB),
    .N(StAng - 1)
  ) u_ang_delay (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  (ang1_q),
    .q_o  (ang_late)
  );

  aavr_cordic #(
    .STAGES(CORDIC_STAGES)
  ) u_cordic (
    .clk_i  (clk_i),
    .en_i   (en),
    .angle_i(ang_late),
    .cos_o  (cos_v),
    .sin_o  (sin_v)
  );

  aavr_combine #(
    .CB(CB)
  ) u_combine (
    .clk_i(clk_i),
    .en_i (en),
    .k_i  (k_q),
    .v_i  (v_k),
    .cos_i(cos_v),
    .sin_i(sin_v),
    .rot_o(rot)
  );

  assign out_o.valid         = vld_q[StOut-1];
  assign out_o.rot_x         = rot[0];
  assign out_o.rot_y         = rot[1];
  assign out_o.rot_z         = rot[2];
  assign out_o.axis_was_zero = zero_out;

  // An accepted item enters the first stage.
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> vld_q[0])
    else $error("accepted item did not enter the pipeline");

  // A held result freezes every stage.
  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during a stall");

  // A zero axis yields a zero unit axis.
  a_zero_axis : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_q[StQuo-1] && zero_q71 |=> k_q[0] == '0 && k_q[1] == '0 && k_q[2] == '0)
    else $error("zero axis produced a nonzero unit axis");

endmodule

`default_nettype wire
